/* design/assert_macros.svh */
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SSG_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ssg assertion failed");

// next-cycle implication
`define SSG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ssg assertion failed");

`endif

/* design/ssg_pkg.sv */
`default_nettype none

package ssg_pkg;

	localparam int MAX_DIGITS = 10;
	localparam int VALUE_W    = 32;
	localparam int BCD_W      = 4 * MAX_DIGITS;
	localparam int DCNT_W     = $clog2(MAX_DIGITS + 1);
	localparam int BCNT_W     = $clog2(VALUE_W);

	localparam logic [6:0] SEG_MINUS = 7'h40;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_MINUS,
		ST_DIGITS
	} state_t;

	typedef struct packed {
		logic load;
		logic conv;
		logic minus;
		logic digit;
	} cmd_t;

	typedef struct packed {
		logic conv_last;
		logic neg;
		logic skip;
		logic last;
		logic out_free;
	} sts_t;

	// segment patterns for digits 0 to 9, bit 6 the middle bar; other codes give a blank glyph
	function automatic logic [6:0] glyph_seg(input logic [3:0] d);
		logic [6:0] s;
		case (d)
			4'd0: s = 7'h3F;
			4'd1: s = 7'h06;
			4'd2: s = 7'h5B;
			4'd3: s = 7'h4F;
			4'd4: s = 7'h66;
			4'd5: s = 7'h6D;
			4'd6: s = 7'h7D;
			4'd7: s = 7'h07;
			4'd8: s = 7'h7F;
			4'd9: s = 7'h6F;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

/* design/ssg_datapath.sv */
`default_nettype none

module ssg_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ssg_pkg::cmd_t                 cmd,
	input  wire logic signed [ssg_pkg::VALUE_W-1:0] value,
	output ssg_pkg::sts_t                      sts,
	input  wire logic                          out_stall,
	output logic                               out_valid,
	output logic                               is_minus,
	output logic [3:0]                         digit,
	output logic [6:0]                         segments,
	output logic                               last
);

	logic [ssg_pkg::VALUE_W-1:0] bin_q;
	logic [ssg_pkg::BCD_W-1:0]   bcd_q;
	logic [ssg_pkg::BCD_W-1:0]   adj;
	logic [ssg_pkg::VALUE_W-1:0] mag;
	logic                        ovf_q;
	logic                        neg_q;
	logic                        lead_q;
	logic [ssg_pkg::BCNT_W-1:0]  cnt_q;
	logic [ssg_pkg::DCNT_W-1:0]  dig_left_q;
	logic [3:0]                  top;
	logic                        skip;
	logic                        emit_digit;
	logic                        out_valid_q;
	logic                        is_minus_q;
	logic [3:0]                  digit_q;
	logic [6:0]                  segments_q;
	logic                        last_q;

	assign mag = value[ssg_pkg::VALUE_W-1] ? (~value + 1'b1) : value;

	// add 3 to every digit of 5 or more
	always_comb begin
		adj = bcd_q;
		for (int i = 0; i < ssg_pkg::MAX_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end
		end
	end

	assign top        = bcd_q[ssg_pkg::BCD_W-1 -: 4];
	assign skip       = lead_q && (top == 4'd0) && !ovf_q
	                    && (dig_left_q != ssg_pkg::DCNT_W'(1));
	assign emit_digit = cmd.digit && !skip;

	assign sts.conv_last = (cnt_q == ssg_pkg::BCNT_W'(ssg_pkg::VALUE_W - 1));
	assign sts.neg       = neg_q;
	assign sts.skip      = skip;
	assign sts.last      = (dig_left_q == ssg_pkg::DCNT_W'(1));
	assign sts.out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			dig_left_q  <= '0;
			lead_q      <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q      <= '0;
				dig_left_q <= ssg_pkg::DCNT_W'(ssg_pkg::MAX_DIGITS);
				lead_q     <= 1'b1;
			end
			if (cmd.conv) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.digit) begin
				dig_left_q <= dig_left_q - 1'b1;
				if (!skip) begin
					lead_q <= 1'b0;
				end
			end
			if (emit_digit || cmd.minus) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= mag;
			bcd_q <= '0;
			ovf_q <= 1'b0;
			neg_q <= value[ssg_pkg::VALUE_W-1];
		end
		if (cmd.conv) begin
			bin_q <= bin_q << 1;
			bcd_q <= {adj[ssg_pkg::BCD_W-2:0], bin_q[ssg_pkg::VALUE_W-1]};
			ovf_q <= ovf_q | adj[ssg_pkg::BCD_W-1];
		end
		if (cmd.digit) begin
			bcd_q <= bcd_q << 4;
		end
		if (cmd.minus) begin
			is_minus_q <= 1'b1;
			digit_q    <= 4'd0;
			segments_q <= ssg_pkg::SEG_MINUS;
			last_q     <= 1'b0;
		end
		if (emit_digit) begin
			is_minus_q <= 1'b0;
			digit_q    <= top;
			segments_q <= ssg_pkg::glyph_seg(top);
			last_q     <= (dig_left_q == ssg_pkg::DCNT_W'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign is_minus  = is_minus_q;
	assign digit     = digit_q;
	assign segments  = segments_q;
	assign last      = last_q;

endmodule

`default_nettype wire

/* design/ssg_ctrl.sv */
`default_nettype none

module ssg_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire ssg_pkg::sts_t sts,
	output ssg_pkg::cmd_t      cmd
);

	ssg_pkg::state_t state_q;
	ssg_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssg_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		case (state_q)
			ssg_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ssg_pkg::ST_CONV;
				end
			end
			ssg_pkg::ST_CONV: begin
				cmd.conv = 1'b1;
				if (sts.conv_last) begin
					state_nxt = sts.neg ? ssg_pkg::ST_MINUS : ssg_pkg::ST_DIGITS;
				end
			end
			ssg_pkg::ST_MINUS: begin
				if (sts.out_free) begin
					cmd.minus = 1'b1;
					state_nxt = ssg_pkg::ST_DIGITS;
				end
			end
			ssg_pkg::ST_DIGITS: begin
				if (sts.skip || sts.out_free) begin
					cmd.digit = 1'b1;
					if (sts.last) begin
						state_nxt = ssg_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = ssg_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* design/signed_int_to_seven_segment_glyphs.sv */
// Converts one signed 32-bit request to a run of seven-segment glyphs, most
// significant first, leading zeros dropped; a negative value gets a leading
// minus glyph and zero gives one 0 glyph. A request passes through
// shift-and-add-3 conversion in the bcd register, the minus glyph if
// negative, then one digit position per cycle (MAX_DIGITS of them,
// suppressed zeros included) while the output is not stalled, and then back
// to idle to take the next request. The input is stalled from acceptance
// until the last glyph is loaded into the output register.
`default_nettype none

module signed_int_to_seven_segment_glyphs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [ssg_pkg::VALUE_W-1:0] value,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic                                    is_minus,
	output logic [3:0]                              digit,
	output logic [6:0]                              segments,
	output logic                                    last
);

	ssg_pkg::cmd_t cmd;
	ssg_pkg::sts_t sts;

	ssg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ssg_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.value     (value),
		.sts       (sts),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.is_minus  (is_minus),
		.digit     (digit),
		.segments  (segments),
		.last      (last)
	);

endmodule

`default_nettype wire

/* design/ssg_checker.sv */
`default_nettype none

`include "assert_macros.svh"

module ssg_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       is_minus,
	input wire logic [3:0] digit,
	input wire logic [6:0] segments,
	input wire logic       last
);

	logic minus_ok;
	logic digit_ok;

	assign minus_ok = (segments == ssg_pkg::SEG_MINUS) && (digit == 4'd0) && !last;
	assign digit_ok = (digit <= 4'd9) && (segments == ssg_pkg::glyph_seg(digit));

	`SSG_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall)
	`SSG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({segments, last}))
	`SSG_ASSERT(a_minus_glyph, out_valid && is_minus, minus_ok)
	`SSG_ASSERT(a_digit_glyph, out_valid && !is_minus, digit_ok)

endmodule

bind signed_int_to_seven_segment_glyphs ssg_checker u_ssg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.is_minus  (is_minus),
	.digit     (digit),
	.segments  (segments),
	.last      (last)
);

`default_nettype wire

/* tb/tb_signed_int_to_seven_segment_glyphs.sv */
`timescale 1ns / 100ps

module tb_signed_int_to_seven_segment_glyphs;

	typedef struct packed {
		logic       is_minus;
		logic [3:0] digit;
		logic [6:0] segments;
		logic       last;
	} glyph_t;

	// one stimulus row; typed rows carry up to two glyphs written out by hand
	typedef struct packed {
		logic signed [ssg_pkg::VALUE_W-1:0] value;
		logic                               typed;
		logic [1:0]                         n_typed;
		glyph_t                             g0;
		glyph_t                             g1;
	} row_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_LONG
	} stall_mode_t;

	localparam logic [6:0] DIGIT_ART [10] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
	};

	localparam glyph_t NO_GLYPH    = '0;
	localparam glyph_t MINUS_GLYPH = '{1'b1, 4'd0, 7'h40, 1'b0};

	localparam int N_DIRECTED = 19;
	localparam int N_RANDOM   = 250;

	localparam row_t DIRECTED [N_DIRECTED] = '{
		'{32'sd0,           1'b1, 2'd1, '{1'b0, 4'd0, 7'h3F, 1'b1}, NO_GLYPH},
		'{32'sd1,           1'b1, 2'd1, '{1'b0, 4'd1, 7'h06, 1'b1}, NO_GLYPH},
		'{32'sd9,           1'b1, 2'd1, '{1'b0, 4'd9, 7'h6F, 1'b1}, NO_GLYPH},
		'{-32'sd1,          1'b1, 2'd2, MINUS_GLYPH, '{1'b0, 4'd1, 7'h06, 1'b1}},
		'{-32'sd8,          1'b1, 2'd2, MINUS_GLYPH, '{1'b0, 4'd8, 7'h7F, 1'b1}},
		'{32'sh7FFFFFFF,    1'b0, 2'd0, NO_GLYPH, NO_GLYPH},
		'{32'sh80000000,    1'b0, 2'd0, NO_GLYPH, NO_GLYPH},
		'{32'sh80000001,    1'b0, 2'd0, NO_GLYPH, NO_GLYPH},
		'{32'sd10,          1'b0, 2'd0, NO_GLYPH, NO_GLYPH},
		'{-32'sd10,         1'b0, 2'd0, NO_GLYPH, NO_GLYPH},
		'{32'sd100,         1'b0, 2'd0, NO_GLYPH, NO_GLYPH},
		'{32'sd1000000000,  1'b0, 2'd0, NO_GLYPH, NO_GLYPH},
		'{-32'sd1000000000, 1'b0, 2'd0, NO_GLYPH, NO_GLYPH},
		'{32'sd999999999,   1'b0, 2'd0, NO_GLYPH, NO_GLYPH},
		'{32'sd1234567890,  1'b0, 2'd0, NO_GLYPH, NO_GLYPH},
		'{-32'sd1023456789, 1'b0, 2'd0, NO_GLYPH, NO_GLYPH},
		'{32'sh55555555,    1'b0, 2'd0, NO_GLYPH, NO_GLYPH},
		'{32'shAAAAAAAA,    1'b0, 2'd0, NO_GLYPH, NO_GLYPH},
		'{-32'sd7,          1'b0, 2'd0, NO_GLYPH, NO_GLYPH}
	};

	logic                               clk;
	logic                               arst_n;
	logic                               in_valid;
	logic                               in_stall;
	logic signed [ssg_pkg::VALUE_W-1:0] value;
	logic                               out_valid;
	logic                               out_stall;
	logic                               is_minus;
	logic [3:0]                         digit;
	logic [6:0]                         segments;
	logic                               last;

	glyph_t pending_glyphs [$];
	row_t   requests [$];
	int     n_requests;
	int     n_negative;
	int     n_glyphs;
	int     n_errors;

	signed_int_to_seven_segment_glyphs i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.is_minus  (is_minus),
		.digit     (digit),
		.segments  (segments),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4ms;
		$display("timeout with %0d glyphs outstanding", pending_glyphs.size());
		$display("TEST FAILED");
		$finish;
	end

	// decimal digits of the magnitude, most significant first, minus glyph in front
	function automatic void predict_glyphs(input logic [ssg_pkg::VALUE_W-1:0] raw);
		logic [ssg_pkg::VALUE_W-1:0] mag;
		logic [3:0]                  digs [ssg_pkg::MAX_DIGITS];
		int                          n;
		n = 0;
		mag = raw[ssg_pkg::VALUE_W-1] ? -raw : raw;
		do begin
			digs[n] = 4'(mag % 10);
			mag = mag / 10;
			n++;
		end while (mag != 0 && n < ssg_pkg::MAX_DIGITS);
		if (raw[ssg_pkg::VALUE_W-1])
			pending_glyphs.push_back(MINUS_GLYPH);
		for (int i = n - 1; i >= 0; i--)
			pending_glyphs.push_back('{1'b0, digs[i], DIGIT_ART[digs[i]], i == 0});
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("%0t: glyph %0d %s mismatch: got %0h, expected %0h",
			$realtime, n_glyphs, field, got, want);
		n_errors++;
	endtask

	always @(posedge clk) begin
		glyph_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_glyphs.size() == 0) begin
				report_mismatch("unrequested glyph", 1, 0);
			end else begin
				want = pending_glyphs.pop_front();
				if (is_minus !== want.is_minus)
					report_mismatch("is_minus", is_minus, want.is_minus);
				if (digit !== want.digit)
					report_mismatch("digit", digit, want.digit);
				if (segments !== want.segments)
					report_mismatch("segments", segments, want.segments);
				if (last !== want.last)
					report_mismatch("last", last, want.last);
			end
			n_glyphs++;
		end
	end

	// receiver: runs of no stall, random stall, and long stall bursts
	initial begin
		stall_mode_t mode;
		int          span;
		int          phase;
		phase = 0;
		out_stall = 1'b0;
		forever begin
			mode = stall_mode_t'($urandom_range(0, 2));
			span = $urandom_range(40, 300);
			repeat (span) begin
				@(negedge clk);
				phase++;
				case (mode)
					STALL_NONE: out_stall <= 1'b0;
					STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
					default: out_stall <= (phase % 17) >= 5;
				endcase
			end
		end
	end

	initial begin
		row_t r;
		int   burst_left;
		int   nd;
		int   v;
		arst_n = 1'b0;
		in_valid = 1'b0;
		value = '0;
		n_requests = 0;
		n_negative = 0;
		n_glyphs = 0;
		n_errors = 0;

		foreach (DIRECTED[i])
			requests.push_back(DIRECTED[i]);
		repeat (N_RANDOM) begin
			case ($urandom_range(0, 3))
				0: v = $urandom;
				1: begin
					nd = $urandom_range(1, 9);
					v = $urandom_range(0, 10 ** nd - 1);
					if ($urandom_range(0, 1))
						v = -v;
				end
				2: begin
					if ($urandom_range(0, 1))
						v = 32'h7FFFFFFF - $urandom_range(0, 20);
					else
						v = 32'h80000000 + $urandom_range(0, 20);
				end
				default: v = $urandom_range(0, 20) * ($urandom_range(0, 1) ? -1 : 1);
			endcase
			requests.push_back('{v, 1'b0, 2'd0, NO_GLYPH, NO_GLYPH});
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		burst_left = $urandom_range(1, 8);
		foreach (requests[i]) begin
			r = requests[i];
			if (i == N_DIRECTED || i == N_DIRECTED + N_RANDOM / 2) begin
				// hold off until the block has drained
				in_valid <= 1'b0;
				while (pending_glyphs.size() != 0)
					@(negedge clk);
				@(negedge clk);
			end else if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				burst_left = $urandom_range(1, 8);
			end
			in_valid <= 1'b1;
			value <= r.value;
			@(posedge clk);
			while (in_stall)
				@(posedge clk);
			if (r.typed) begin
				pending_glyphs.push_back(r.g0);
				if (r.n_typed == 2)
					pending_glyphs.push_back(r.g1);
			end else begin
				predict_glyphs(r.value);
			end
			n_requests++;
			if (r.value < 0)
				n_negative++;
			if (burst_left > 0)
				burst_left--;
			@(negedge clk);
		end
		in_valid <= 1'b0;

		while (pending_glyphs.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		$display("%0d requests (%0d negative, extremes and zero included), %0d glyphs checked",
			n_requests, n_negative, n_glyphs);
		$display("%0d mismatches under bursty input and mixed output stall", n_errors);
		if (n_errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
